@@ rtl/radial_falloff_pair_force_macros.svh @@
// Assertion macros shared by the radial falloff force RTL.
`ifndef RADIAL_FALLOFF_PAIR_FORCE_MACROS_SVH
`define RADIAL_FALLOFF_PAIR_FORCE_MACROS_SVH
`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define RFPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every clock edge, reset included.
`define RFPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RFPF_ASSERT(lbl, prop, msg)
`define RFPF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/rfpf_pkg.sv @@
// Constants and types shared by the radial falloff force pipeline.
package rfpf_pkg;

  localparam int CW          = 24;              // coordinate width
  localparam int DW          = CW + 1;          // coordinate difference width
  localparam int RW          = 23;              // radius width
  localparam int GW          = 16;              // gain width
  localparam int FW          = 25;              // force width
  localparam int LANES       = 3;
  localparam int CIW         = 2;               // register index width
  localparam int MGW         = RW;              // in-range difference magnitude
  localparam int SQW         = 2 * MGW;         // squared magnitude
  localparam int SQRT_STEPS  = SQW / 2 + 6;     // sqrt of sum_sq * 4096
  localparam int RADW        = 2 * SQRT_STEPS;  // radicand width
  localparam int LW          = SQRT_STEPS;      // length width
  localparam int DIV_RW      = LW + 2;          // divisor / remainder width
  localparam int DIV_LW      = FW - 1;          // dividend low bits, quotient width
  localparam int PCT_STEPS   = 17;
  localparam int MAGW        = GW + PCT_STEPS;
  localparam int NUMW        = MGW + MAGW;
  localparam int FDIV_STEPS  = DIV_LW;

  localparam logic [CIW-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CIW-1:0] CFG_GAIN   = 2'd1;

  localparam logic [RW-1:0] RADIUS_RST = 23'd25600;
  localparam logic [GW-1:0] GAIN_RST   = 16'd256;

  typedef struct packed {
    logic [RADW-1:0] rad;
    logic [LW-1:0]   root;
    logic [LW+1:0]   rem;
  } sqrt_t;

  typedef struct packed {
    logic [DIV_RW-1:0] rem;
    logic [DIV_RW-1:0] den;
    logic [DIV_LW-1:0] low;
    logic [DIV_LW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic                      vld;
    logic                      att;
    logic [LANES-1:0]          neg;
    logic                      inr;
    logic                      zro;
    logic [LANES-1:0]          ovf;
    logic [LANES-1:0][MGW-1:0] mg;
    logic [LW-1:0]             len;
  } side_t;

  typedef struct packed {
    logic [LANES-1:0][FW-1:0] frc;
    logic                     inr;
  } res_t;

endpackage

@@ rtl/radial_falloff_pair_force.sv @@
// Top level of the radial falloff pair force pipeline.
//
//   channel   direction  handshake                 payload
//   request   in         req_valid_i / req_ready_o req_type_i, agent_*_i, source_*_i
//   result    out        res_valid_o / res_ready_i force_*_o, in_range_o
//   config    in         cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One request is accepted per cycle while the result buffer is not full. The
// depth is set by the 29-cell square root chain, the 17-cell falloff divider
// and the 24-cell force divider, plus seven arithmetic stages.
// Reset clears the stage valid bits and the result buffer and loads the radius
// and gain defaults. The whole chain advances together; it holds only when the
// two-entry result buffer is full, so requests keep flowing while one result waits.
`include "radial_falloff_pair_force_macros.svh"

module radial_falloff_pair_force (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rfpf_pkg::CIW-1:0]            cfg_idx_i,
  input  logic [rfpf_pkg::RW-1:0]             cfg_wdata_i,
  input  logic                                req_valid_i,
  output logic                                req_ready_o,
  input  logic                                req_type_i,
  input  logic signed [rfpf_pkg::CW-1:0]      agent_x_i,
  input  logic signed [rfpf_pkg::CW-1:0]      agent_y_i,
  input  logic signed [rfpf_pkg::CW-1:0]      agent_z_i,
  input  logic signed [rfpf_pkg::CW-1:0]      source_x_i,
  input  logic signed [rfpf_pkg::CW-1:0]      source_y_i,
  input  logic signed [rfpf_pkg::CW-1:0]      source_z_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output logic signed [rfpf_pkg::FW-1:0]      force_x_o,
  output logic signed [rfpf_pkg::FW-1:0]      force_y_o,
  output logic signed [rfpf_pkg::FW-1:0]      force_z_o,
  output logic                                in_range_o
);

  localparam int LANES = rfpf_pkg::LANES;

  // Configuration registers. The user must change them only while the pipeline
  // is empty, which the block does not enforce; every stage reads them directly.
  logic [rfpf_pkg::RW-1:0] radius_q;
  logic [rfpf_pkg::GW-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= rfpf_pkg::RADIUS_RST;
      gain_q   <= rfpf_pkg::GAIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rfpf_pkg::CFG_RADIUS: radius_q <= cfg_wdata_i;
        rfpf_pkg::CFG_GAIN:   gain_q   <= cfg_wdata_i[rfpf_pkg::GW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves unless the result buffer is full.
  logic [1:0] cnt_q;
  logic       en;

  assign en          = (cnt_q != 2'd2);
  assign req_ready_o = en;

  // Stage 1: coordinate differences.
  logic signed [rfpf_pkg::CW-1:0] crd_a [LANES];
  logic signed [rfpf_pkg::CW-1:0] crd_s [LANES];
  logic                           s1_vld_q;
  logic                           s1_att_q;
  logic signed [rfpf_pkg::DW-1:0] s1_dif_q [LANES];

  assign crd_a[0] = agent_x_i;
  assign crd_a[1] = agent_y_i;
  assign crd_a[2] = agent_z_i;
  assign crd_s[0] = source_x_i;
  assign crd_s[1] = source_y_i;
  assign crd_s[2] = source_z_i;

  // Stage 2: sign and magnitude.
  logic                           s2_vld_q;
  logic                           s2_att_q;
  logic [LANES-1:0]               s2_neg_q;
  logic [rfpf_pkg::DW-1:0]        s2_mag_q [LANES];

  // Stage 3: squares and the per-axis range test.
  logic                           s3_vld_q;
  logic                           s3_att_q;
  logic [LANES-1:0]               s3_neg_q;
  logic                           s3_inr_q;
  logic [rfpf_pkg::MGW-1:0]       s3_mg_q  [LANES];
  logic [rfpf_pkg::SQW-1:0]       s3_sq_q  [LANES];
  logic [rfpf_pkg::SQW-1:0]       s3_rsq_q;
  logic                           s3_inr_d;

  // Stage 4: sum of squares and the exact radius test.
  rfpf_pkg::side_t                s4_side_q;
  rfpf_pkg::side_t                s4_side_d;
  logic [rfpf_pkg::SQW-1:0]       s4_sum_q;
  logic [rfpf_pkg::SQW+1:0]       s4_sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= req_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_comb begin
    s3_inr_d = (radius_q != '0);
    for (int i = 0; i < LANES; i++) begin
      if (s2_mag_q[i] > {2'b00, radius_q}) begin
        s3_inr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_att_q <= req_type_i;
      s2_att_q <= s1_att_q;
      s3_att_q <= s2_att_q;
      s3_neg_q <= s2_neg_q;
      s3_inr_q <= s3_inr_d;
      s3_rsq_q <= radius_q * radius_q;
      for (int i = 0; i < LANES; i++) begin
        s1_dif_q[i] <= rfpf_pkg::DW'(crd_a[i]) - rfpf_pkg::DW'(crd_s[i]);
        s2_neg_q[i] <= s1_dif_q[i][rfpf_pkg::DW-1];
        s2_mag_q[i] <= s1_dif_q[i][rfpf_pkg::DW-1] ? (~s1_dif_q[i] + 1'b1) : s1_dif_q[i];
        s3_mg_q[i]  <= s2_mag_q[i][rfpf_pkg::MGW-1:0];
        s3_sq_q[i]  <= s2_mag_q[i][rfpf_pkg::MGW-1:0] * s2_mag_q[i][rfpf_pkg::MGW-1:0];
      end
      s4_sum_q <= s4_sum_d[rfpf_pkg::SQW-1:0];
    end
  end

  always_comb begin
    s4_sum_d = {2'b00, s3_sq_q[0]} + {2'b00, s3_sq_q[1]} + {2'b00, s3_sq_q[2]};
    s4_side_d     = '0;
    s4_side_d.vld = s3_vld_q;
    s4_side_d.att = s3_att_q;
    s4_side_d.neg = s3_neg_q;
    s4_side_d.inr = s3_inr_q && (s4_sum_d <= {2'b00, s3_rsq_q});
    s4_side_d.zro = (s4_sum_d == '0);
    for (int i = 0; i < LANES; i++) begin
      s4_side_d.mg[i] = s3_mg_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_side_q <= '0;
    end else if (en) begin
      s4_side_q <= s4_side_d;
    end
  end

  // Square root chain: length in 2^-6 units, the root of sum_sq * 4096.
  rfpf_pkg::sqrt_t sq_in;
  rfpf_pkg::sqrt_t sq_s      [rfpf_pkg::SQRT_STEPS];
  rfpf_pkg::side_t sq_side_q [rfpf_pkg::SQRT_STEPS];

  assign sq_in.rad  = {s4_sum_q, 12'd0};
  assign sq_in.root = '0;
  assign sq_in.rem  = '0;

  for (genvar k = 0; k < rfpf_pkg::SQRT_STEPS; k++) begin : g_sqrt
    rfpf_pkg::sqrt_t cin;
    rfpf_pkg::side_t sin;
    if (k == 0) begin : g_head
      assign cin = sq_in;
      assign sin = s4_side_q;
    end else begin : g_body
      assign cin = sq_s[k-1];
      assign sin = sq_side_q[k-1];
    end
    rfpf_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (cin),
      .q_o   (sq_s[k])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_side_q[k] <= '0;
      end else if (en) begin
        sq_side_q[k] <= sin;
      end
    end
  end

  // Falloff divider: pct = ((64r - L) << 16) / 64r.
  logic [rfpf_pkg::LW-1:0] pc_len;
  logic [rfpf_pkg::LW-1:0] pc_r64;
  logic [rfpf_pkg::LW-1:0] pc_dif;
  rfpf_pkg::div_t          pc_in;
  rfpf_pkg::side_t         pc_side_in;
  rfpf_pkg::div_t          pc_s      [rfpf_pkg::PCT_STEPS];
  rfpf_pkg::side_t         pc_side_q [rfpf_pkg::PCT_STEPS];

  always_comb begin
    pc_len     = sq_s[rfpf_pkg::SQRT_STEPS-1].root;
    pc_r64     = {radius_q, 6'd0};
    pc_dif     = pc_r64 - pc_len;
    pc_in.rem  = {3'b000, pc_dif[rfpf_pkg::LW-1:1]};
    pc_in.den  = {2'b00, pc_r64};
    pc_in.low  = {pc_dif[0], {(rfpf_pkg::DIV_LW-1){1'b0}}};
    pc_in.quo  = '0;
    pc_side_in     = sq_side_q[rfpf_pkg::SQRT_STEPS-1];
    pc_side_in.len = pc_len;
  end

  for (genvar k = 0; k < rfpf_pkg::PCT_STEPS; k++) begin : g_pct
    rfpf_pkg::div_t  cin;
    rfpf_pkg::side_t sin;
    if (k == 0) begin : g_head
      assign cin = pc_in;
      assign sin = pc_side_in;
    end else begin : g_body
      assign cin = pc_s[k-1];
      assign sin = pc_side_q[k-1];
    end
    rfpf_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .d_i   (cin),
      .q_o   (pc_s[k])
    );
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pc_side_q[k] <= '0;
      end else if (en) begin
        pc_side_q[k] <= sin;
      end
    end
  end

  // Gain scaling, then the split product |d| * mag and its recombination.
  logic [rfpf_pkg::PCT_STEPS-1:0]       m_pct;
  logic [rfpf_pkg::MAGW-1:0]            m_mag_q;
  rfpf_pkg::side_t                      m_side_q;
  logic [rfpf_pkg::MGW+rfpf_pkg::PCT_STEPS-1:0] n_plo_q [LANES];
  logic [rfpf_pkg::MGW+rfpf_pkg::GW-1:0]        n_phi_q [LANES];
  rfpf_pkg::side_t                      n_side_q;
  logic [rfpf_pkg::NUMW-1:0]            o_num_q [LANES];
  rfpf_pkg::side_t                      o_side_q;

  assign m_pct = pc_s[rfpf_pkg::PCT_STEPS-1].quo[rfpf_pkg::PCT_STEPS-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mag_q <= rfpf_pkg::MAGW'(gain_q) * rfpf_pkg::MAGW'(m_pct);
      for (int i = 0; i < LANES; i++) begin
        n_plo_q[i] <= (rfpf_pkg::MGW+rfpf_pkg::PCT_STEPS)'(m_side_q.mg[i])
                    * (rfpf_pkg::MGW+rfpf_pkg::PCT_STEPS)'(m_mag_q[rfpf_pkg::PCT_STEPS-1:0]);
        n_phi_q[i] <= (rfpf_pkg::MGW+rfpf_pkg::GW)'(m_side_q.mg[i])
                    * (rfpf_pkg::MGW+rfpf_pkg::GW)'(m_mag_q[rfpf_pkg::MAGW-1:rfpf_pkg::PCT_STEPS]);
        o_num_q[i] <= rfpf_pkg::NUMW'(n_plo_q[i])
                    + (rfpf_pkg::NUMW'(n_phi_q[i]) << rfpf_pkg::PCT_STEPS);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_side_q <= '0;
      n_side_q <= '0;
      o_side_q <= '0;
    end else if (en) begin
      m_side_q <= pc_side_q[rfpf_pkg::PCT_STEPS-1];
      n_side_q <= m_side_q;
      o_side_q <= n_side_q;
    end
  end

  // Force dividers, one lane per axis: |d| * mag / 4L. A quotient that would
  // not fit in 24 bits is flagged up front and saturates at the end.
  logic [rfpf_pkg::DIV_RW-1:0] fd_den;
  rfpf_pkg::div_t              fd_in [LANES];
  rfpf_pkg::side_t             fd_side_in;
  rfpf_pkg::div_t              fd_s      [LANES][rfpf_pkg::FDIV_STEPS];
  rfpf_pkg::side_t             fd_side_q [rfpf_pkg::FDIV_STEPS];

  always_comb begin
    fd_den     = {o_side_q.len, 2'b00};
    fd_side_in = o_side_q;
    for (int i = 0; i < LANES; i++) begin
      fd_in[i].rem = o_num_q[i][rfpf_pkg::NUMW-2:rfpf_pkg::DIV_LW];
      fd_in[i].den = fd_den;
      fd_in[i].low = o_num_q[i][rfpf_pkg::DIV_LW-1:0];
      fd_in[i].quo = '0;
      fd_side_in.ovf[i] = (o_num_q[i][rfpf_pkg::NUMW-1:rfpf_pkg::DIV_LW] >= {1'b0, fd_den});
    end
  end

  for (genvar k = 0; k < rfpf_pkg::FDIV_STEPS; k++) begin : g_fdiv
    rfpf_pkg::side_t sin;
    if (k == 0) begin : g_head
      assign sin = fd_side_in;
    end else begin : g_body
      assign sin = fd_side_q[k-1];
    end
    for (genvar i = 0; i < LANES; i++) begin : g_lane
      rfpf_pkg::div_t cin;
      if (k == 0) begin : g_head
        assign cin = fd_in[i];
      end else begin : g_body
        assign cin = fd_s[i][k-1];
      end
      rfpf_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (en),
        .d_i   (cin),
        .q_o   (fd_s[i][k])
      );
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        fd_side_q[k] <= '0;
      end else if (en) begin
        fd_side_q[k] <= sin;
      end
    end
  end

  // Saturate, apply the sign and zero the force for out-of-range or
  // zero-length pairs.
  rfpf_pkg::side_t         fs;
  rfpf_pkg::res_t          push_res;
  logic [rfpf_pkg::FW-1:0] fval;
  logic                    fneg;

  always_comb begin
    fs           = fd_side_q[rfpf_pkg::FDIV_STEPS-1];
    push_res.inr = fs.inr;
    fval         = '0;
    fneg         = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      fval = fs.ovf[i] ? {1'b0, {rfpf_pkg::DIV_LW{1'b1}}}
                       : {1'b0, fd_s[i][rfpf_pkg::FDIV_STEPS-1].quo};
      fneg = fs.neg[i] ^ fs.att;
      if (fs.inr && !fs.zro) begin
        push_res.frc[i] = fneg ? (~fval + 1'b1) : fval;
      end else begin
        push_res.frc[i] = '0;
      end
    end
  end

  // Two-entry result buffer.
  rfpf_pkg::res_t res_mem [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_d;
  logic           push;
  logic           pop;

  assign push  = fs.vld && en;
  assign pop   = res_valid_o && res_ready_i;
  assign cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_mem[wr_ptr_q] <= push_res;
    end
  end

  assign res_valid_o = (cnt_q != 2'd0);
  assign force_x_o   = res_mem[rd_ptr_q].frc[0];
  assign force_y_o   = res_mem[rd_ptr_q].frc[1];
  assign force_z_o   = res_mem[rd_ptr_q].frc[2];
  assign in_range_o  = res_mem[rd_ptr_q].inr;

  `RFPF_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= 2'd2, "result buffer count overflow")
  `RFPF_ASSERT(a_stall_waits, !req_ready_o |-> res_valid_o, "stalled with no result waiting")
  `RFPF_ASSERT(a_accept_enters, (req_valid_i && req_ready_o) |=> s1_vld_q, "request lost at entry")
  `RFPF_ASSERT(a_oor_zero, (res_valid_o && !in_range_o) |-> (force_x_o == '0 && force_y_o == '0 && force_z_o == '0), "nonzero force out of range")

endmodule

@@ rtl/rfpf_sqrt_cell.sv @@
// One digit step of the pipelined integer square root.
module rfpf_sqrt_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  rfpf_pkg::sqrt_t       d_i,
  output rfpf_pkg::sqrt_t       q_o
);

  logic [rfpf_pkg::LW+3:0] t;
  logic [rfpf_pkg::LW+3:0] trial;
  logic [rfpf_pkg::LW+3:0] dif;
  logic                    ge;
  rfpf_pkg::sqrt_t         state_d;
  rfpf_pkg::sqrt_t         state_q;

  always_comb begin
    t     = {d_i.rem, d_i.rad[rfpf_pkg::RADW-1 -: 2]};
    trial = {2'b00, d_i.root, 2'b01};
    ge    = (t >= trial);
    dif   = t - trial;
    state_d.rad  = d_i.rad << 2;
    state_d.root = {d_i.root[rfpf_pkg::LW-2:0], ge};
    state_d.rem  = ge ? dif[rfpf_pkg::LW+1:0] : t[rfpf_pkg::LW+1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign q_o = state_q;

endmodule

@@ rtl/rfpf_div_cell.sv @@
// One quotient bit of the pipelined restoring divider.
module rfpf_div_cell (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  rfpf_pkg::div_t        d_i,
  output rfpf_pkg::div_t        q_o
);

  logic [rfpf_pkg::DIV_RW:0] t;
  logic [rfpf_pkg::DIV_RW:0] den_x;
  logic [rfpf_pkg::DIV_RW:0] dif;
  logic                      ge;
  rfpf_pkg::div_t            state_d;
  rfpf_pkg::div_t            state_q;

  always_comb begin
    t     = {d_i.rem, d_i.low[rfpf_pkg::DIV_LW-1]};
    den_x = {1'b0, d_i.den};
    ge    = (t >= den_x);
    dif   = t - den_x;
    state_d.rem = ge ? dif[rfpf_pkg::DIV_RW-1:0] : t[rfpf_pkg::DIV_RW-1:0];
    state_d.den = d_i.den;
    state_d.low = d_i.low << 1;
    state_d.quo = {d_i.quo[rfpf_pkg::DIV_LW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign q_o = state_q;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the radial falloff pair force pipeline.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Index outside the register map; writes to it must be ignored.
  localparam logic [rfpf_pkg::CIW-1:0] CFG_UNMAPPED = 2'd2;
  localparam longint unsigned FORCE_SAT = 64'd16777215;
  localparam logic REQ_REPULSE = 1'b0;
  localparam logic REQ_ATTRACT = 1'b1;
  localparam int SETTLE_CYCLES = 100;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [rfpf_pkg::FW-1:0] fx;
    logic [rfpf_pkg::FW-1:0] fy;
    logic [rfpf_pkg::FW-1:0] fz;
    logic                    inr;
  } force_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [rfpf_pkg::CIW-1:0] cfg_idx_i;
  logic [rfpf_pkg::RW-1:0] cfg_wdata_i;
  logic req_valid_i, req_ready_o, req_type_i;
  logic signed [rfpf_pkg::CW-1:0] agent_x_i, agent_y_i, agent_z_i;
  logic signed [rfpf_pkg::CW-1:0] source_x_i, source_y_i, source_z_i;
  logic res_valid_o, res_ready_i;
  logic signed [rfpf_pkg::FW-1:0] force_x_o, force_y_o, force_z_o;
  logic in_range_o;

  radial_falloff_pair_force dut (.*);

  // Shadow copies of the two registers, as the predictor sees them.
  longint unsigned radius_q = 25600;
  longint unsigned gain_q = 256;
  force_t expected_forces[$];
  int mismatches = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Expected force on the agent for one request, from the current registers.
  function automatic force_t falloff_force(logic typ, logic [3*rfpf_pkg::CW-1:0] agent,
                                           logic [3*rfpf_pkg::CW-1:0] source);
    longint d;
    longint unsigned md[3];
    logic [rfpf_pkg::FW-1:0] fo[3];
    bit nd[3];
    bit inr;
    longint unsigned ssq, len, r64, pct, mag, f;
    force_t r;
    inr = (radius_q != 0);
    ssq = 0;
    for (int i = 0; i < 3; i++) begin
      d = longint'($signed(agent[i*rfpf_pkg::CW +: rfpf_pkg::CW]))
        - longint'($signed(source[i*rfpf_pkg::CW +: rfpf_pkg::CW]));
      nd[i] = d < 0;
      md[i] = nd[i] ? longint'(-d) : d;
      if (md[i] > radius_q) inr = 0;
      fo[i] = '0;
    end
    if (inr) begin
      for (int i = 0; i < 3; i++) ssq += md[i] * md[i];
      if (ssq > radius_q * radius_q) inr = 0;
    end
    if (inr && ssq != 0) begin
      len = isqrt(ssq << 12);
      r64 = radius_q << 6;
      pct = ((r64 - len) << 16) / r64;
      mag = gain_q * pct;
      for (int i = 0; i < 3; i++) begin
        f = (md[i] * mag) / (len << 2);
        if (f > FORCE_SAT) f = FORCE_SAT;
        // Saturate first so that attraction is the exact negation.
        fo[i] = (nd[i] != typ) ? rfpf_pkg::FW'(-f) : rfpf_pkg::FW'(f);
      end
    end
    r.fx = fo[0];
    r.fy = fo[1];
    r.fz = fo[2];
    r.inr = inr;
    return r;
  endfunction

  // Receiver side: random back-pressure on the result channel.
  always @(posedge clk_i) begin
    if (rst_ni) res_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Result checker and inactivity watchdog.
  always @(posedge clk_i) begin
    force_t got, want;
    if (rst_ni) begin
      if ((req_valid_i && req_ready_o) || (res_valid_o && res_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
      if (res_valid_o && res_ready_i) begin
        got = '{force_x_o, force_y_o, force_z_o, in_range_o};
        if (expected_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_forces.pop_front();
          if (got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz ||
              got.inr !== want.inr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected f=(%h %h %h) in=%b, got f=(%h %h %h) in=%b",
                       want.fx, want.fy, want.fz, want.inr,
                       got.fx, got.fy, got.fz, got.inr);
          end
        end
      end
    end
  end

  // Sends one request and records its expected result on acceptance.
  task automatic send_pair(logic typ, logic [3*rfpf_pkg::CW-1:0] agent,
                           logic [3*rfpf_pkg::CW-1:0] source);
    while ($urandom_range(99) < send_idle) begin
      req_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_type_i <= typ;
    {agent_z_i, agent_y_i, agent_x_i} <= agent;
    {source_z_i, source_y_i, source_x_i} <= source;
    do @(posedge clk_i); while (!req_ready_o);
    expected_forces.push_back(falloff_force(typ, agent, source));
  endtask

  // Waits until every outstanding request has produced its result.
  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_forces.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rfpf_pkg::CIW-1:0] idx, logic [rfpf_pkg::RW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == rfpf_pkg::CFG_RADIUS) radius_q = val;
    else if (idx == rfpf_pkg::CFG_GAIN) gain_q = val[rfpf_pkg::GW-1:0];
    @(posedge clk_i);
  endtask

  function automatic logic [rfpf_pkg::CW-1:0] rand_coord();
    return rfpf_pkg::CW'($urandom);
  endfunction

  function automatic logic [3*rfpf_pkg::CW-1:0] rand_point();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic logic rand_type();
    return 1'($urandom_range(1));
  endfunction

  // Offset of up to the given magnitude on each axis, wrapped to coordinate width.
  function automatic logic [3*rfpf_pkg::CW-1:0] near_point(logic [3*rfpf_pkg::CW-1:0] p,
                                                           longint unsigned span);
    logic [3*rfpf_pkg::CW-1:0] q;
    longint off;
    for (int i = 0; i < 3; i++) begin
      off = longint'({$urandom, $urandom} % (2 * span + 1)) - longint'(span);
      q[i*rfpf_pkg::CW +: rfpf_pkg::CW] = p[i*rfpf_pkg::CW +: rfpf_pkg::CW]
                                        + rfpf_pkg::CW'(off);
    end
    return q;
  endfunction

  task automatic test_directed();
    logic [3*rfpf_pkg::CW-1:0] org, maxp, minp;
    org = '0;
    maxp = {3{24'h7FFFFF}};
    minp = {3{24'h800000}};
    // Zero length gives zero force but counts as in range.
    send_pair(REQ_REPULSE, org, org);
    send_pair(REQ_ATTRACT, maxp, maxp);
    // Coordinate extremes; far out of range at the default radius.
    send_pair(REQ_REPULSE, maxp, minp);
    send_pair(REQ_ATTRACT, minp, maxp);
    // Single axis just inside, on and just past the radius.
    send_pair(REQ_REPULSE, {48'd0, 24'd25599}, org);
    send_pair(REQ_ATTRACT, {48'd0, 24'd25600}, org);
    send_pair(REQ_REPULSE, {48'd0, 24'd25601}, org);
    // Every axis inside the radius; sum of squares outside it for the first pair only.
    send_pair(REQ_REPULSE, {3{24'd20000}}, org);
    send_pair(REQ_ATTRACT, org, {3{24'd100}});
    send_pair(REQ_REPULSE, {24'hFFFFFF, 24'd1, 24'd5}, org);
    drain();
    // Full gain near zero distance gives large forces.
    write_reg(rfpf_pkg::CFG_GAIN, 23'hFFFF);
    send_pair(REQ_REPULSE, {48'd0, 24'd1}, org);
    send_pair(REQ_ATTRACT, {48'd0, 24'd1}, org);
    send_pair(REQ_REPULSE, {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, org);
    send_pair(REQ_ATTRACT, {24'd3, 24'hFFFFFE, 24'd7}, org);
    drain();
    // A radius of zero disables the force even at zero length.
    write_reg(rfpf_pkg::CFG_RADIUS, '0);
    write_reg(CFG_UNMAPPED, 23'h7FFFFF);
    send_pair(REQ_REPULSE, org, org);
    send_pair(REQ_ATTRACT, {48'd0, 24'd1}, org);
    drain();
    // Largest radius with axis separations at or just under the radius.
    write_reg(rfpf_pkg::CFG_RADIUS, 23'h7FFFFF);
    write_reg(rfpf_pkg::CFG_GAIN, '0);
    send_pair(REQ_REPULSE, {24'h3FFFFF, 48'd0}, {24'hC00000, 48'd0});
    drain();
    write_reg(rfpf_pkg::CFG_GAIN, 23'd1);
    send_pair(REQ_ATTRACT, {24'h3FFFFF, 48'd0}, {24'hC00001, 48'd0});
    send_pair(REQ_REPULSE, maxp, {3{24'h000001}});
    drain();
  endtask

  // Random phase: mostly pairs near the radius, with some fully random pairs.
  task automatic test_random(int count, int s_idle, int r_idle);
    logic [3*rfpf_pkg::CW-1:0] src;
    longint unsigned span;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) begin
      src = rand_point();
      span = (radius_q == 0) ? 64'd50 : radius_q + radius_q / 4 + 1;
      if ($urandom_range(9) < 8) send_pair(rand_type(), near_point(src, span), src);
      else send_pair(rand_type(), rand_point(), src);
    end
    drain();
  endtask

  task automatic test_settings();
    // Each setting is loaded while the pipeline is empty.
    write_reg(rfpf_pkg::CFG_RADIUS, 23'd25600);
    write_reg(rfpf_pkg::CFG_GAIN, 23'd256);
    test_random(250, 0, 0);
    write_reg(rfpf_pkg::CFG_RADIUS, 23'h7FFFFF);
    write_reg(rfpf_pkg::CFG_GAIN, 23'hFFFF);
    test_random(200, 79, 0);
    write_reg(rfpf_pkg::CFG_RADIUS, 23'd1);
    write_reg(rfpf_pkg::CFG_GAIN, 23'd1);
    test_random(150, 0, 79);
    write_reg(rfpf_pkg::CFG_RADIUS, 23'd300);
    write_reg(rfpf_pkg::CFG_GAIN, 23'hFFFF);
    test_random(150, 7, 7);
    write_reg(rfpf_pkg::CFG_RADIUS, 23'd0);
    test_random(50, 7, 7);
    write_reg(rfpf_pkg::CFG_RADIUS, rfpf_pkg::RW'($urandom));
    write_reg(rfpf_pkg::CFG_GAIN, rfpf_pkg::RW'($urandom_range(16'hFFFF)));
    test_random(350, 0, 0);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    req_valid_i = 1'b0;
    req_type_i = 1'b0;
    {agent_x_i, agent_y_i, agent_z_i} = '0;
    {source_x_i, source_y_i, source_z_i} = '0;
    res_ready_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_settings();
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ radial_falloff_pair_force.f @@
+incdir+rtl
rtl/rfpf_pkg.sv
rtl/rfpf_sqrt_cell.sv
rtl/rfpf_div_cell.sv
rtl/radial_falloff_pair_force.sv
bench/tb_top.sv
